[rtl/core/hbsd_pkg.sv]
// Package for the bit-serial Huffman decoder core: payload structs, codes,
// table geometry and the controller state type. No dependencies.
`default_nettype none

package hbsd_pkg;

	// Code table geometry and pattern width.
	localparam int PATTERN_BITS  = 13;
	localparam int TABLE_DEPTH   = 8192;
	localparam int BITS_PER_BYTE = 8;
	localparam int MAX_CODE_LEN  = 12;

	// The code length limit is clamped so that the pattern register can hold it.
	localparam int CODE_LIMIT = (MAX_CODE_LEN < 1) ? 1 :
		((MAX_CODE_LEN > PATTERN_BITS - 1) ? PATTERN_BITS - 1 : MAX_CODE_LEN);
	localparam logic [PATTERN_BITS-1:0] LIMIT_PAT = PATTERN_BITS'(1 << CODE_LIMIT);
	localparam logic [PATTERN_BITS-1:0] SENTINEL  = PATTERN_BITS'(1);

	// Operation codes of a command item.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] ST_SYMBOL = 2'd0;
	localparam logic [1:0] ST_LONG   = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [12:0] table_code;
		logic [7:0]  table_symbol;
		logic        table_valid;
		logic [15:0] message_length;
		logic [7:0]  data_byte;
		logic        final_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic [1:0] status;
		logic       message_done;
		logic       last_of_run;
	} res_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_BIT,
		S_FINAL
	} state_t;

endpackage

`default_nettype wire

[rtl/core/huffman_bit_serial_decoder_core.sv]
// Bit-serial Huffman decoder core: code table memory, bit shifter, result
// holding register and output register. Depends on hbsd_pkg.
// A data byte is accepted, then each code bit is evaluated in turn (one
// table read per bit) and the byte is closed, with an extra closing step
// when it ends in a short-message report; the core stalls while a result
// is held back at the result port. No new item is taken until the byte is
// closed. The last result of a byte moves from the holding register to the
// output register as the byte is closed. Reset clears the pattern and symbol
// count at once, then a clearing pass writes all 8192 table entries invalid,
// one per cycle; no item is accepted during the pass.
`default_nettype none

module huffman_bit_serial_decoder_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire hbsd_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_ready,
	output hbsd_pkg::res_t     res
);

	localparam int AW = $clog2(hbsd_pkg::TABLE_DEPTH);

	// Controller state and datapath registers.
	hbsd_pkg::state_t state_q, state_d;
	logic [AW-1:0]                     clr_cnt_q;
	logic [hbsd_pkg::PATTERN_BITS-1:0] pat_q;
	logic [15:0]                       sym_left_q;
	logic [6:0]                        byte_q;
	logic [2:0]                        bit_cnt_q;
	logic                              fin_q;
	logic                              pend_valid_q;
	hbsd_pkg::res_t                    pend_q;
	logic                              out_valid_q;
	hbsd_pkg::res_t                    out_q;

	// Code table memory with registered read data.
	logic [8:0]    table_mem [hbsd_pkg::TABLE_DEPTH];
	logic [8:0]    rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [8:0]    wr_data;

	// Control signals.
	logic                              accept;
	logic                              out_free;
	logic                              hit;
	logic                              sym_nz;
	logic                              emit_sym;
	logic                              emit_long;
	logic                              short_rep;
	logic                              new_res;
	hbsd_pkg::res_t                    new_val;
	logic                              advance;
	logic                              push_out;
	logic                              push_last;
	logic                              last_bit;
	logic [hbsd_pkg::PATTERN_BITS-1:0] pat_base;

	assign cmd_ready = (state_q == hbsd_pkg::S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign out_free  = !out_valid_q || res_ready;

	// Evaluation of the current lookup and of the end-of-byte report.
	always_comb begin
		hit       = rd_q[8];
		sym_nz    = (sym_left_q != 16'd0);
		emit_sym  = hit && sym_nz;
		emit_long = !hit && (pat_q >= hbsd_pkg::LIMIT_PAT);
		short_rep = fin_q && sym_nz;
		last_bit  = (bit_cnt_q == 3'(hbsd_pkg::BITS_PER_BYTE - 1));
		pat_base  = (hit || emit_long) ? hbsd_pkg::SENTINEL : pat_q;
		new_res   = 1'b0;
		new_val   = '0;
		advance   = 1'b0;
		push_last = 1'b0;
		case (state_q)
			hbsd_pkg::S_BIT: begin
				new_res = emit_sym || emit_long;
				if (emit_sym) begin
					new_val.symbol       = rd_q[7:0];
					new_val.status       = hbsd_pkg::ST_SYMBOL;
					new_val.message_done = (sym_left_q == 16'd1);
				end else begin
					new_val.status = hbsd_pkg::ST_LONG;
				end
				advance = !(new_res && pend_valid_q && !out_free);
			end
			hbsd_pkg::S_FINAL: begin
				new_res              = short_rep;
				new_val.status       = hbsd_pkg::ST_SHORT;
				new_val.message_done = 1'b1;
				push_last            = !short_rep;
				advance              = !(pend_valid_q && !out_free);
			end
			default: begin
				advance = 1'b0;
			end
		endcase
		push_out = advance && pend_valid_q && (new_res || push_last);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			hbsd_pkg::S_CLEAR: begin
				if (clr_cnt_q == AW'(hbsd_pkg::TABLE_DEPTH - 1)) begin
					state_d = hbsd_pkg::S_IDLE;
				end
			end
			hbsd_pkg::S_IDLE: begin
				if (accept && cmd.operation == hbsd_pkg::OP_DECODE) begin
					state_d = hbsd_pkg::S_BIT;
				end
			end
			hbsd_pkg::S_BIT: begin
				if (advance && last_bit) begin
					state_d = hbsd_pkg::S_FINAL;
				end
			end
			hbsd_pkg::S_FINAL: begin
				if (advance && !short_rep) begin
					state_d = hbsd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hbsd_pkg::S_CLEAR;
			end
		endcase
	end

	// Table port control: clearing pass and loads write, decode bits read.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.table_code;
		wr_data = {cmd.table_valid, cmd.table_symbol};
		rd_en   = 1'b0;
		rd_addr = {pat_q[AW-2:0], cmd.data_byte[0]};
		if (state_q == hbsd_pkg::S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else if (accept && cmd.operation == hbsd_pkg::OP_LOAD) begin
			wr_en = 1'b1;
		end
		if (accept && cmd.operation == hbsd_pkg::OP_DECODE) begin
			rd_en = 1'b1;
		end else if (state_q == hbsd_pkg::S_BIT && advance && !last_bit) begin
			rd_en   = 1'b1;
			rd_addr = {pat_base[AW-2:0], byte_q[0]};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= table_mem[rd_addr];
		end
	end

	// State, pattern and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hbsd_pkg::S_CLEAR;
			clr_cnt_q  <= '0;
			pat_q      <= hbsd_pkg::SENTINEL;
			sym_left_q <= '0;
			bit_cnt_q  <= '0;
			fin_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hbsd_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (accept && cmd.operation == hbsd_pkg::OP_START) begin
				sym_left_q <= cmd.message_length;
				pat_q      <= hbsd_pkg::SENTINEL;
			end
			if (accept && cmd.operation == hbsd_pkg::OP_DECODE) begin
				pat_q     <= {pat_q[hbsd_pkg::PATTERN_BITS-2:0], cmd.data_byte[0]};
				bit_cnt_q <= '0;
				fin_q     <= cmd.final_byte;
			end
			if (state_q == hbsd_pkg::S_BIT && advance) begin
				if (emit_sym) begin
					sym_left_q <= sym_left_q - 16'd1;
				end
				if (last_bit) begin
					pat_q <= fin_q ? hbsd_pkg::SENTINEL : pat_base;
				end else begin
					pat_q     <= {pat_base[hbsd_pkg::PATTERN_BITS-2:0], byte_q[0]};
					bit_cnt_q <= bit_cnt_q + 3'd1;
				end
			end
			if (state_q == hbsd_pkg::S_FINAL && advance && short_rep) begin
				sym_left_q <= '0;
			end
		end
	end

	// Byte shifter: one code bit leaves per evaluated bit.
	always_ff @(posedge clk) begin
		if (accept && cmd.operation == hbsd_pkg::OP_DECODE) begin
			byte_q <= cmd.data_byte[7:1];
		end else if (state_q == hbsd_pkg::S_BIT && advance && !last_bit) begin
			byte_q <= {1'b0, byte_q[6:1]};
		end
	end

	// The newest result waits here until it is known whether it ends the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (advance && new_res) begin
			pend_valid_q <= 1'b1;
		end else if (advance && push_last) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && new_res) begin
			pend_q <= new_val;
		end
	end

	// Output register: loaded from the held result, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_q <= {pend_q.symbol, pend_q.status, pend_q.message_done, push_last};
		end
	end

endmodule

`default_nettype wire

[tb/huffman_bit_serial_decoder_core_tb.sv]
// Testbench for huffman_bit_serial_decoder_core: directed and random command streams,
// a shadow copy of the code table and pattern state, and an in-order result scoreboard.
// Depends on hbsd_pkg and the core RTL.

module huffman_bit_serial_decoder_core_tb;

	// Operation code that the core must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int STALL_LIMIT  = 50000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 370;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	hbsd_pkg::cmd_t cmd;
	logic res_valid;
	logic res_ready;
	hbsd_pkg::res_t res;

	// Shadow of the core state, updated at every command transfer.
	logic [8:0]                        shadow_codes [hbsd_pkg::TABLE_DEPTH];
	logic [hbsd_pkg::PATTERN_BITS-1:0] shadow_pattern;
	logic [15:0]                       shadow_left;
	hbsd_pkg::res_t                    pending_decodes [$];

	// Table addresses written valid since the last cleanup.
	logic [hbsd_pkg::PATTERN_BITS-1:0] live_codes [$];

	int err_count = 0;
	int sent_items = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	huffman_bit_serial_decoder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Number of code bits below the sentinel of a pattern.
	function automatic int code_len(input logic [hbsd_pkg::PATTERN_BITS-1:0] p);
		int n;
		n = 0;
		for (int k = 1; k < hbsd_pkg::PATTERN_BITS; k++) begin
			if (p[k]) begin
				n = k;
			end
		end
		return n;
	endfunction

	// Work out the results of one transferred command and queue them.
	function automatic void decode_cmd(input hbsd_pkg::cmd_t c);
		hbsd_pkg::res_t run_out [9];
		int             n;
		logic [8:0]     entry;
		n = 0;
		case (c.operation)
			hbsd_pkg::OP_LOAD: begin
				shadow_codes[c.table_code] = {c.table_valid, c.table_symbol};
			end
			hbsd_pkg::OP_START: begin
				shadow_left    = c.message_length;
				shadow_pattern = hbsd_pkg::SENTINEL;
			end
			hbsd_pkg::OP_DECODE: begin
				for (int i = 0; i < hbsd_pkg::BITS_PER_BYTE; i++) begin
					shadow_pattern = {shadow_pattern[hbsd_pkg::PATTERN_BITS-2:0],
						c.data_byte[i]};
					entry = shadow_codes[shadow_pattern];
					if (entry[8]) begin
						// A hit past the expected count is dropped.
						if (shadow_left != 16'd0) begin
							run_out[n].symbol       = entry[7:0];
							run_out[n].status       = hbsd_pkg::ST_SYMBOL;
							run_out[n].message_done = (shadow_left == 16'd1);
							run_out[n].last_of_run  = 1'b0;
							n++;
							shadow_left = shadow_left - 16'd1;
						end
						shadow_pattern = hbsd_pkg::SENTINEL;
					end else if (shadow_pattern >= hbsd_pkg::LIMIT_PAT) begin
						run_out[n].symbol       = 8'd0;
						run_out[n].status       = hbsd_pkg::ST_LONG;
						run_out[n].message_done = 1'b0;
						run_out[n].last_of_run  = 1'b0;
						n++;
						shadow_pattern = hbsd_pkg::SENTINEL;
					end
				end
				if (c.final_byte) begin
					if (shadow_left != 16'd0) begin
						run_out[n].symbol       = 8'd0;
						run_out[n].status       = hbsd_pkg::ST_SHORT;
						run_out[n].message_done = 1'b1;
						run_out[n].last_of_run  = 1'b0;
						n++;
						shadow_left = 16'd0;
					end
					shadow_pattern = hbsd_pkg::SENTINEL;
				end
			end
			default: begin
			end
		endcase
		if (n > 0) begin
			run_out[n-1].last_of_run = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			pending_decodes.push_back(run_out[k]);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Compare one result transfer with the oldest expected result.
	task automatic check_result(input hbsd_pkg::res_t got);
		hbsd_pkg::res_t want;
		if (pending_decodes.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: symbol %02h status %0d",
				got.symbol, got.status));
		end else begin
			want = pending_decodes.pop_front();
			if (got.symbol !== want.symbol)
				report_mismatch($sformatf("symbol %02h, expected %02h", got.symbol, want.symbol));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.message_done !== want.message_done)
				report_mismatch($sformatf("message_done %0b, expected %0b",
					got.message_done, want.message_done));
			if (got.last_of_run !== want.last_of_run)
				report_mismatch($sformatf("last_of_run %0b, expected %0b",
					got.last_of_run, want.last_of_run));
		end
	endtask

	// Transfer monitor and watchdog; values sampled here are those before the edge.
	always @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			decode_cmd(cmd);
		end
		if (res_valid && res_ready) begin
			check_result(res);
		end
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: a random stall before each result, none while idling is off.
	initial begin
		int stall;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	// Send one command and return at the edge of its transfer.
	task automatic send_cmd(input hbsd_pkg::cmd_t c);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		if (c.operation == hbsd_pkg::OP_LOAD && c.table_valid) begin
			live_codes.push_back(c.table_code);
		end
		if (c.operation != OP_UNUSED) begin
			sent_items++;
		end
	endtask

	// Command builders; fields that the operation does not use carry random values.
	function automatic hbsd_pkg::cmd_t random_cmd();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(hbsd_pkg::cmd_t)-1:0];
	endfunction

	function automatic hbsd_pkg::cmd_t load_item(
		input logic [hbsd_pkg::PATTERN_BITS-1:0] code,
		input logic [7:0] sym, input logic v);
		hbsd_pkg::cmd_t c;
		c = random_cmd();
		c.operation    = hbsd_pkg::OP_LOAD;
		c.table_code   = code;
		c.table_symbol = sym;
		c.table_valid  = v;
		return c;
	endfunction

	function automatic hbsd_pkg::cmd_t start_item(input logic [15:0] len);
		hbsd_pkg::cmd_t c;
		c = random_cmd();
		c.operation      = hbsd_pkg::OP_START;
		c.message_length = len;
		return c;
	endfunction

	function automatic hbsd_pkg::cmd_t byte_item(input logic [7:0] b, input logic fin);
		hbsd_pkg::cmd_t c;
		c = random_cmd();
		c.operation  = hbsd_pkg::OP_DECODE;
		c.data_byte  = b;
		c.final_byte = fin;
		return c;
	endfunction

	// Table extremes: address zero, the all-ones code, a one-bit code, an unused operation.
	task automatic test_table_edges();
		hbsd_pkg::cmd_t c;
		idle_on = 1'b1;
		send_cmd(load_item(13'd0, 8'hA5, 1'b1));
		send_cmd(load_item(13'h1FFF, 8'hFF, 1'b1));
		send_cmd(load_item(13'd2, 8'h00, 1'b1));
		c = '1;
		c.operation = OP_UNUSED;
		send_cmd(c);
	endtask

	// Hits beyond the count are dropped; a full byte plus a short report gives nine results.
	task automatic test_symbol_count();
		send_cmd(start_item(16'd3));
		send_cmd(byte_item(8'h00, 1'b0));
		send_cmd(start_item(16'hFFFF));
		send_cmd(byte_item(8'h00, 1'b1));
	endtask

	// A pattern that reaches the length limit without a hit is flagged, count or not.
	task automatic test_long_code();
		send_cmd(load_item(13'd2, 8'h00, 1'b0));
		send_cmd(load_item(13'h1FFF, 8'h00, 1'b0));
		send_cmd(start_item(16'd0));
		send_cmd(byte_item(8'hFF, 1'b0));
		send_cmd(byte_item(8'hFF, 1'b0));
		send_cmd(byte_item(8'h00, 1'b1));
	endtask

	// Final bytes with the count met, with the count short, and with no count at all.
	task automatic test_short_message();
		idle_on = 1'b0;
		send_cmd(load_item(13'd3, 8'h7E, 1'b1));
		send_cmd(start_item(16'd4));
		send_cmd(byte_item(8'h0F, 1'b1));
		send_cmd(start_item(16'd10));
		send_cmd(byte_item(8'h01, 1'b1));
		send_cmd(byte_item(8'h01, 1'b1));
	endtask

	// Fully random commands, the unused operation among them.
	task automatic send_noise(input int count);
		repeat (count) begin
			send_cmd(random_cmd());
		end
	endtask

	// Random prefix codes, messages encoded with them, and some broken sequences.
	task automatic test_random_messages();
		logic [hbsd_pkg::PATTERN_BITS-1:0] leaves [$];
		logic [hbsd_pkg::PATTERN_BITS-1:0] loaded [$];
		logic [hbsd_pkg::PATTERN_BITS-1:0] stale [$];
		logic [hbsd_pkg::PATTERN_BITS-1:0] p;
		bit                                stream [$];
		int                                target;
		int                                pick;
		int                                n_sym;
		int                                mode;
		logic [15:0]                       len;
		logic [7:0]                        b;
		logic                              fin;
		target = sent_items + RANDOM_ITEMS;
		while (sent_items < target) begin
			idle_on = ($urandom_range(0, 3) != 0);

			// Clear the previous code, except now and then.
			if ($urandom_range(0, 5) != 0) begin
				stale = live_codes;
				live_codes.delete();
				foreach (stale[k]) begin
					send_cmd(load_item(stale[k], 8'($urandom), 1'b0));
				end
			end

			// Grow a random code tree by splitting leaves, often the newest one.
			leaves.delete();
			leaves.push_back(hbsd_pkg::SENTINEL);
			repeat ($urandom_range(1, 24)) begin
				pick = ($urandom_range(0, 1) == 0) ? leaves.size() - 1 :
					$urandom_range(0, leaves.size() - 1);
				p = leaves[pick];
				if (code_len(p) < hbsd_pkg::CODE_LIMIT) begin
					leaves.delete(pick);
					leaves.push_back({p[hbsd_pkg::PATTERN_BITS-2:0], 1'b0});
					leaves.push_back({p[hbsd_pkg::PATTERN_BITS-2:0], 1'b1});
				end
			end

			// Load most leaves; the rest stay holes that end in a length flag.
			loaded.delete();
			foreach (leaves[k]) begin
				if ($urandom_range(0, 7) != 0) begin
					send_cmd(load_item(leaves[k], 8'($urandom), 1'b1));
					loaded.push_back(leaves[k]);
				end
			end

			// Encode a message, code bits in arrival order.
			n_sym = $urandom_range(1, 24);
			stream.delete();
			repeat (n_sym) begin
				if (loaded.size() > 0 && $urandom_range(0, 9) != 0)
					p = loaded[$urandom_range(0, loaded.size() - 1)];
				else
					p = leaves[$urandom_range(0, leaves.size() - 1)];
				for (int k = code_len(p) - 1; k >= 0; k--) begin
					stream.push_back(p[k]);
				end
			end

			// Mostly the true count; sometimes too many, too few or no start at all.
			mode = $urandom_range(0, 9);
			if (mode == 0)
				len = 16'(n_sym + $urandom_range(1, 3));
			else if (mode == 1)
				len = 16'($urandom_range(0, n_sym - 1));
			else
				len = 16'(n_sym);
			if (mode != 2) begin
				send_cmd(start_item(len));
			end

			// Pack into bytes, padding the last one with random bits.
			while (stream.size() > 0) begin
				b = 8'($urandom);
				for (int k = 0; k < hbsd_pkg::BITS_PER_BYTE; k++) begin
					if (stream.size() > 0) begin
						b[k] = stream.pop_front();
					end
				end
				fin = (stream.size() == 0) && ($urandom_range(0, 7) != 0);
				send_cmd(byte_item(b, fin));
			end

			if ($urandom_range(0, 3) == 0) begin
				send_noise($urandom_range(4, 12));
			end
		end
	endtask

	// Reset, directed tests, random messages, then drain and verdict.
	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		for (int a = 0; a < hbsd_pkg::TABLE_DEPTH; a++) begin
			shadow_codes[a] = 9'd0;
		end
		shadow_pattern = hbsd_pkg::SENTINEL;
		shadow_left    = 16'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_table_edges();
		test_symbol_count();
		test_long_code();
		test_short_message();
		test_random_messages();

		cmd_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
